@@ src/cfe_pkg.sv @@
// ----------------------------------------------------------------------------
// cfe_pkg: shared types and constants for the clip playhead and fade envelope
// Config register indexes, clip_control field layout, fade curve codes and
// the control word that travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // source frame indexes and most config registers
    localparam int SRC_BITS = 32;

    // config port
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CLIP_START      = 3'd0,
        CFG_CLIP_LENGTH     = 3'd1,
        CFG_SOURCE_OFFSET   = 3'd2,
        CFG_SOURCE_LENGTH   = 3'd3,
        CFG_SOURCE_FRAMES   = 3'd4,
        CFG_FADE_IN_FRAMES  = 3'd5,
        CFG_FADE_OUT_FRAMES = 3'd6,
        CFG_CLIP_CONTROL    = 3'd7
    } cfg_idx_t;

    // clip_control layout
    localparam int CTL_BITS     = 22;
    localparam int CTL_LOOP     = 0;
    localparam int CTL_MUTE     = 1;
    localparam int CTL_FI_LSB   = 2;
    localparam int CTL_FO_LSB   = 4;
    localparam int CTL_GAIN_LSB = 6;
    localparam int GAIN_BITS    = 16;
    localparam logic [CTL_BITS-1:0] CTL_RESET = 22'h040000;

    // envelope output
    localparam int ENV_BITS = 16;

    // fade curve codes
    typedef enum logic [1:0] {
        CURVE_LINEAR     = 2'd0,
        CURVE_SQUARE     = 2'd1,
        CURVE_INV_SQUARE = 2'd2,
        CURVE_SMOOTH     = 2'd3
    } curve_t;

    // per-item control bits carried along the pipeline
    typedef struct packed {
        logic vld;
        logic in_clip;
        logic fi_act;
        logic fo_act;
    } pipe_ctl_t;

endpackage

@@ src/cfe_div_pipe.sv @@
// ----------------------------------------------------------------------------
// cfe_div_pipe: pipelined restoring dividers, one bit per stage
// Lane one gives the playhead offset modulo the usable length. Two more lanes
// give the fade-in and fade-out fractions floor(n * 2^F / d) with n <= d.
// ----------------------------------------------------------------------------
module cfe_div_pipe #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfe_pkg::pipe_ctl_t            in_ctl,
    input  logic [cfe_pkg::SRC_BITS-1:0]  in_p,
    input  logic [cfe_pkg::SRC_BITS-1:0]  in_nfo,
    input  logic [cfe_pkg::SRC_BITS-1:0]  usable,
    input  logic [cfe_pkg::SRC_BITS-1:0]  fade_in,
    input  logic [cfe_pkg::SRC_BITS-1:0]  fade_out,
    output cfe_pkg::pipe_ctl_t            out_ctl,
    output logic [cfe_pkg::SRC_BITS-1:0]  out_p,
    output logic [cfe_pkg::SRC_BITS-1:0]  out_rem,
    output logic [FRACTION_BITS:0]        out_qi,
    output logic [FRACTION_BITS:0]        out_qo
);

    localparam int W  = cfe_pkg::SRC_BITS;
    localparam int QW = FRACTION_BITS + 1;

    cfe_pkg::pipe_ctl_t ctl_reg [W];
    logic [W-1:0]       p_reg   [W];
    logic [W-1:0]       rem_reg [W];
    logic [W-1:0]       fr_reg  [W][2];
    logic [QW-1:0]      q_reg   [W][2];
    logic [W-1:0]       den     [2];

    assign den[0] = fade_in;
    assign den[1] = fade_out;

    for (genvar k = 0; k < W; k++) begin : g_stage
        cfe_pkg::pipe_ctl_t ctl_in;
        logic [W-1:0]       p_in;
        logic [W-1:0]       rem_in;
        logic [W-1:0]       rem_next;
        logic [W:0]         rs;
        logic               rge;

        if (k == 0) begin : g_first
            assign ctl_in = in_ctl;
            assign p_in   = in_p;
            assign rem_in = '0;
        end
        else begin : g_rest
            assign ctl_in = ctl_reg[k-1];
            assign p_in   = p_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        // modulo lane: bring in the next dividend bit, subtract if it fits
        assign rs       = {rem_in, p_in[W-1-k]};
        assign rge      = rs >= {1'b0, usable};
        assign rem_next = rge ? W'(rs - {1'b0, usable}) : rs[W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            p_reg[k]   <= p_in;
            rem_reg[k] <= rem_next;
        end

        // fraction lanes: 0 fade-in, 1 fade-out
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [W-1:0]  fr_in;
            logic [W-1:0]  fr_next;
            logic [QW-1:0] q_in;
            logic [QW-1:0] q_next;

            if (k == 0) begin : g_src
                assign fr_in = (l == 0) ? in_p : in_nfo;
                assign q_in  = '0;
            end
            else begin : g_chain
                assign fr_in = fr_reg[k-1][l];
                assign q_in  = q_reg[k-1][l];
            end

            if (k <= FRACTION_BITS) begin : g_work
                logic [W:0] ts;
                logic       tge;

                // integer bit first, then one fraction bit per stage
                if (k == 0) begin : g_int
                    assign ts = {1'b0, fr_in};
                end
                else begin : g_frac
                    assign ts = {fr_in, 1'b0};
                end

                assign tge     = ts >= {1'b0, den[l]};
                assign fr_next = tge ? W'(ts - {1'b0, den[l]}) : ts[W-1:0];

                always_comb
                begin
                    q_next = q_in;
                    q_next[FRACTION_BITS-k] = tge;
                end
            end
            else begin : g_hold
                assign fr_next = fr_in;
                assign q_next  = q_in;
            end

            always_ff @(posedge clk)
            begin
                fr_reg[k][l] <= fr_next;
                q_reg[k][l]  <= q_next;
            end
        end
    end

    assign out_ctl = ctl_reg[W-1];
    assign out_p   = p_reg[W-1];
    assign out_rem = rem_reg[W-1];
    assign out_qi  = q_reg[W-1][0];
    assign out_qo  = q_reg[W-1][1];

endmodule

@@ src/clip_frame_and_fade_envelope.sv @@
// ----------------------------------------------------------------------------
// clip_frame_and_fade_envelope: clip playhead with fade envelope
// Maps a timeline position to a source frame and a Q4.12 gain envelope.
// ----------------------------------------------------------------------------
// Pipeline: input register, clip offset, range test, the 32-stage divider pipeline,
//   source frame, curve values, fade product and output register lead to done.
// Throughput: one word per cycle; busy is never raised.
// Reset: clears the item valid bits and done and returns config registers to their defaults; frame_valid is not reset.
// The receiver cannot stall: done is a one-cycle strobe.
module clip_frame_and_fade_envelope #(
    parameter int POSITION_BITS = 40,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [POSITION_BITS-1:0]            timeline_position,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [POSITION_BITS-1:0]            cfg_data,
    output logic                                done,
    output logic                                frame_valid,
    output logic [cfe_pkg::SRC_BITS-1:0]        source_frame,
    output logic [cfe_pkg::ENV_BITS-1:0]        envelope,
    output logic                                audible
);

    localparam int W       = cfe_pkg::SRC_BITS;
    localparam int F       = FRACTION_BITS;
    localparam int QW      = F + 1;
    localparam int PB      = POSITION_BITS;
    localparam int LATENCY = 7 + W;
    localparam logic [QW-1:0] ONE_Q     = QW'(1) << F;
    localparam logic [QW+1:0] THREE_ONE = (QW+2)'(3) << F;

    // config registers
    logic [PB-1:0]                clip_start_reg;
    logic [W-1:0]                 clip_length_reg;
    logic [W-1:0]                 source_offset_reg;
    logic [W-1:0]                 source_length_reg;
    logic [W-1:0]                 source_frames_reg;
    logic [W-1:0]                 fade_in_reg;
    logic [W-1:0]                 fade_out_reg;
    logic [cfe_pkg::CTL_BITS-1:0] clip_control_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_start_reg    <= '0;
            clip_length_reg   <= W'(1);
            source_offset_reg <= '0;
            source_length_reg <= '0;
            source_frames_reg <= '0;
            fade_in_reg       <= '0;
            fade_out_reg      <= '0;
            clip_control_reg  <= cfe_pkg::CTL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfe_pkg::cfg_idx_t'(cfg_index))
                cfe_pkg::CFG_CLIP_START:      clip_start_reg    <= cfg_data;
                cfe_pkg::CFG_CLIP_LENGTH:     clip_length_reg   <= cfg_data[W-1:0];
                cfe_pkg::CFG_SOURCE_OFFSET:   source_offset_reg <= cfg_data[W-1:0];
                cfe_pkg::CFG_SOURCE_LENGTH:   source_length_reg <= cfg_data[W-1:0];
                cfe_pkg::CFG_SOURCE_FRAMES:   source_frames_reg <= cfg_data[W-1:0];
                cfe_pkg::CFG_FADE_IN_FRAMES:  fade_in_reg       <= cfg_data[W-1:0];
                cfe_pkg::CFG_FADE_OUT_FRAMES: fade_out_reg      <= cfg_data[W-1:0];
                cfe_pkg::CFG_CLIP_CONTROL:
                    clip_control_reg <= cfg_data[cfe_pkg::CTL_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic                 looped;
    logic                 muted;
    logic [1:0]           curve_code [2];
    logic [cfe_pkg::GAIN_BITS-1:0] gain;

    assign looped        = clip_control_reg[cfe_pkg::CTL_LOOP];
    assign muted         = clip_control_reg[cfe_pkg::CTL_MUTE];
    assign curve_code[0] = clip_control_reg[cfe_pkg::CTL_FI_LSB +: 2];
    assign curve_code[1] = clip_control_reg[cfe_pkg::CTL_FO_LSB +: 2];
    assign gain          = clip_control_reg[cfe_pkg::CTL_GAIN_LSB +: cfe_pkg::GAIN_BITS];

    // usable length, derived from config and held in registers
    logic [W-1:0] avail;
    logic [W-1:0] usable_next;
    logic [W-1:0] usable_reg;
    logic         has_src_reg;

    assign avail       = source_frames_reg - source_offset_reg;
    assign usable_next = (source_length_reg == '0 || source_length_reg > avail)
                         ? avail : source_length_reg;

    always_ff @(posedge clk)
    begin
        usable_reg  <= usable_next;
        has_src_reg <= source_frames_reg > source_offset_reg;
    end

    // stage 0: input word
    logic          v0_reg;
    logic [PB-1:0] pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= timeline_position;
    end

    // stage 1: offset into the clip, borrow marks a position before it
    logic        v1_reg;
    logic [PB:0] diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= {1'b0, pos_reg} - {1'b0, clip_start_reg};
    end

    // stage 2: clip range test, fade activity, fade-out numerator
    cfe_pkg::pipe_ctl_t ctl2_next;
    cfe_pkg::pipe_ctl_t ctl2_reg;
    logic [W-1:0]       p2_next;
    logic [W-1:0]       nfo2_next;
    logic [W-1:0]       p2_reg;
    logic [W-1:0]       nfo2_reg;

    assign p2_next   = diff_reg[W-1:0];
    assign nfo2_next = clip_length_reg - p2_next;

    always_comb
    begin
        ctl2_next.vld     = v1_reg;
        ctl2_next.in_clip = !diff_reg[PB] && (diff_reg[PB-1:0] < PB'(clip_length_reg));
        ctl2_next.fi_act  = (fade_in_reg != '0) && (p2_next < fade_in_reg);
        ctl2_next.fo_act  = (fade_out_reg != '0) && (fade_out_reg >= nfo2_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg   <= p2_next;
        nfo2_reg <= nfo2_next;
    end

    // divider pipeline
    cfe_pkg::pipe_ctl_t dv_ctl;
    logic [W-1:0]       dv_p;
    logic [W-1:0]       dv_rem;
    logic [QW-1:0]      dv_qi;
    logic [QW-1:0]      dv_qo;

    cfe_div_pipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl2_reg),
        .in_p     (p2_reg),
        .in_nfo   (nfo2_reg),
        .usable   (usable_reg),
        .fade_in  (fade_in_reg),
        .fade_out (fade_out_reg),
        .out_ctl  (dv_ctl),
        .out_p    (dv_p),
        .out_rem  (dv_rem),
        .out_qi   (dv_qi),
        .out_qo   (dv_qo)
    );

    // stage 3: source frame, curve squares
    cfe_pkg::pipe_ctl_t ctl3_reg;
    logic               fv3_next;
    logic               fv3_reg;
    logic [W-1:0]       frame3_next;
    logic [W-1:0]       frame3_reg;
    logic [QW-1:0]      x_in   [2];
    logic [QW-1:0]      x3_reg [2];
    logic [QW-1:0]      sq3_reg [2];

    assign x_in[0] = dv_qi;
    assign x_in[1] = dv_qo;

    assign fv3_next    = dv_ctl.in_clip && has_src_reg && (looped || dv_p < usable_reg);
    assign frame3_next = fv3_next ? source_offset_reg + (looped ? dv_rem : dv_p) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else
        begin
            ctl3_reg <= dv_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        fv3_reg    <= fv3_next;
        frame3_reg <= frame3_next;
    end

    // stage 4: curve values
    cfe_pkg::pipe_ctl_t ctl4_reg;
    logic               fv4_reg;
    logic [W-1:0]       frame4_reg;
    logic [QW-1:0]      shape4_reg [2];

    for (genvar l = 0; l < 2; l++) begin : g_curve
        logic [QW-1:0]     sq_base;
        logic [2*QW-1:0]   sq_prod;
        logic [QW+1:0]     tail;
        logic [2*QW+1:0]   sm_prod;
        logic [QW-1:0]     shape_next;

        // inverse square squares the distance from one
        assign sq_base = (cfe_pkg::curve_t'(curve_code[l]) == cfe_pkg::CURVE_INV_SQUARE)
                         ? ONE_Q - x_in[l] : x_in[l];
        assign sq_prod = sq_base * sq_base;

        always_ff @(posedge clk)
        begin
            x3_reg[l]  <= x_in[l];
            sq3_reg[l] <= sq_prod[F +: QW];
        end

        // smoothstep tail 3 - 2x
        assign tail    = THREE_ONE - {1'b0, x3_reg[l], 1'b0};
        assign sm_prod = sq3_reg[l] * tail;

        always_comb
        begin
            case (cfe_pkg::curve_t'(curve_code[l]))
                cfe_pkg::CURVE_LINEAR:     shape_next = x3_reg[l];
                cfe_pkg::CURVE_SQUARE:     shape_next = sq3_reg[l];
                cfe_pkg::CURVE_INV_SQUARE: shape_next = ONE_Q - sq3_reg[l];
                cfe_pkg::CURVE_SMOOTH:     shape_next = sm_prod[F +: QW];
                default:                   shape_next = x3_reg[l];
            endcase
        end

        always_ff @(posedge clk)
        begin
            shape4_reg[l] <= shape_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
        end
        else
        begin
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fv4_reg    <= fv3_reg;
        frame4_reg <= frame3_reg;
    end

    // stage 5: fade-in times fade-out
    cfe_pkg::pipe_ctl_t ctl5_reg;
    logic               fv5_reg;
    logic [W-1:0]       frame5_reg;
    logic [QW-1:0]      fi_gain;
    logic [QW-1:0]      fo_gain;
    logic [2*QW-1:0]    fade_prod;
    logic [QW-1:0]      e5_reg;

    assign fi_gain   = ctl4_reg.fi_act ? shape4_reg[0] : ONE_Q;
    assign fo_gain   = ctl4_reg.fo_act ? shape4_reg[1] : ONE_Q;
    assign fade_prod = fi_gain * fo_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg <= '0;
        end
        else
        begin
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fv5_reg    <= fv4_reg;
        frame5_reg <= frame4_reg;
        e5_reg     <= fade_prod[F +: QW];
    end

    // stage 6: gain, saturation, output word
    logic [QW+cfe_pkg::GAIN_BITS-1:0] gain_prod;
    logic [cfe_pkg::ENV_BITS:0]       env_full;
    logic [cfe_pkg::ENV_BITS-1:0]     env_next;
    logic                             done_reg;
    logic                             frame_valid_reg;
    logic [W-1:0]                     source_frame_reg;
    logic [cfe_pkg::ENV_BITS-1:0]     envelope_reg;
    logic                             audible_reg;

    assign gain_prod = e5_reg * gain;
    assign env_full  = gain_prod[F +: cfe_pkg::ENV_BITS+1];

    always_comb
    begin
        if (!ctl5_reg.in_clip || muted)
            env_next = '0;
        else if (env_full[cfe_pkg::ENV_BITS])
            env_next = '1;
        else
            env_next = env_full[cfe_pkg::ENV_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl5_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_valid_reg  <= fv5_reg;
        source_frame_reg <= frame5_reg;
        envelope_reg     <= env_next;
        audible_reg      <= fv5_reg && (env_next != '0);
    end

    assign done         = done_reg;
    assign frame_valid  = frame_valid_reg;
    assign source_frame = source_frame_reg;
    assign envelope     = envelope_reg;
    assign audible      = audible_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after accepted word");

    a_audible_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && audible) |-> (frame_valid && envelope != '0))
        else $error("audible without frame or envelope");

    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !frame_valid) |-> (source_frame == '0))
        else $error("invalid frame with nonzero index");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl5_reg.vld))
        else $error("result strobe without an item");

endmodule
